>>> sv/music_string_note_parser_core_assert.svh
// Assertion macros for the music string note parser
`ifndef MUSIC_STRING_NOTE_PARSER_CORE_ASSERT_SVH
`define MUSIC_STRING_NOTE_PARSER_CORE_ASSERT_SVH
// a implies b on the same edge
`define MSNP_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a implies b on the next edge
`define MSNP_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

>>> sv/msnp_pkg.sv
// Shared types and constants of the music string note parser
`timescale 1ns / 1ps
package msnp_pkg;
    localparam int DurationBitsDefault = 16;
    localparam logic [1:0] KIND_NOTE = 2'd0;
    localparam logic [1:0] KIND_GAP  = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [7:0] REST_NOTE = 8'd255;

    // one classified character passed from front to back
    typedef struct packed {
        logic       stop;
        logic [7:0] ch;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  note;
        logic [15:0] dur;
        logic        last;
    } t_res;
endpackage

>>> sv/music_string_note_parser_core.sv
// Top level of the music string note parser
`timescale 1ns / 1ps
// A closing or ending character with no divide goes to an emit state that registers its word.
// A note length runs the DURATION_BITS-bit restoring divider once.
// L runs it once and T twice before the next character is parsed.
// Throughput: one character in the back end at a time; a 2-entry queue decouples input.
// Reset: synchronous active-low i_rst_n restores default octave, tempo and length.
module music_string_note_parser_core
    import msnp_pkg::*;
#(
    parameter int DURATION_BITS = DurationBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_note_number,
    output logic [15:0] o_duration_ms,
    output logic        o_last
);
    logic q_valid, q_ready;
    t_cmd q_data;
    t_res res;

    msnp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_ch(i_ch), .o_q_valid(q_valid), .i_q_ready(q_ready),
        .o_q_data(q_data)
    );

    msnp_back #(.DURATION_BITS(DURATION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_ready(q_ready),
        .i_q_data(q_data), .o_valid(o_valid), .i_ready(i_ready), .o_res(res)
    );

    assign o_kind        = res.kind;
    assign o_note_number = res.note;
    assign o_duration_ms = res.dur;
    assign o_last        = res.last;
endmodule

>>> sv/msnp_front.sv
// Front end: accepts characters, folds case, drops spaces, queues commands
`timescale 1ns / 1ps
module msnp_front
    import msnp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_ch,
    output logic       o_q_valid,
    input  logic       i_q_ready,
    output t_cmd       o_q_data
);
    localparam int Depth = 2;
    t_cmd       r_mem [Depth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [7:0] w_lc;
    logic       w_acc, w_push, w_pop;

    assign o_ready   = (r_cnt != 2'(Depth));
    assign w_acc     = i_valid && o_ready;
    assign w_lc      = (i_ch >= 8'h41 && i_ch <= 8'h5a) ? i_ch + 8'h20 : i_ch;
    assign w_push    = w_acc && (i_op || (w_lc != 8'h20));
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= '{stop: i_op, ch: w_lc};
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

>>> sv/msnp_div.sv
// Shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module msnp_div #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, r_d;
    logic [W:0]    r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [W:0]    w_sh;

    assign o_busy = r_busy;
    assign o_quo  = r_q;
    assign w_sh   = {r_rem[W-1:0], r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(W);
            r_q <= i_num;
            r_d <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                r_rem <= w_sh - {1'b0, r_d};
                r_q <= {r_q[W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q <= {r_q[W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
endmodule

>>> sv/msnp_back.sv
// Back end: parser state machine, settings, divides and result output
`timescale 1ns / 1ps
module msnp_back
    import msnp_pkg::*;
#(
    parameter int DURATION_BITS = DurationBitsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_ready,
    input  t_cmd i_q_data,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);
    `include "music_string_note_parser_core_assert.svh"
    localparam int DW = DURATION_BITS;
    localparam logic [DW-1:0] DurMax = '1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ARG_L, PH_ARG_O, PH_ARG_T, PH_MODE,
        PH_SHARP, PH_FLAT, PH_LEN, PH_DOTS
    } t_phase;
    // execution steps of the sequencer
    typedef enum logic [3:0] {
        S_FETCH, S_EXEC, S_DIV_WAIT, S_T_MUL, S_L_DIV, S_EMIT_NOTE, S_EMIT_GAP,
        S_EMIT_END, S_OUT
    } t_step;
    typedef enum logic [1:0] {D_LEN, D_LTYPE, D_TEMPO, D_DEFDUR} t_dsel;

    t_phase      r_ph;
    t_step       r_st;
    t_dsel       r_dsel;
    t_cmd        r_cmd;
    logic [7:0]  r_boct, r_noct, r_pnote;
    logic [DW-1:0] r_whole, r_defdur, r_pdur, r_dinc, r_gap;
    logic [15:0] r_ntype, r_acc;
    logic        r_stacc, r_prest;
    t_res        r_out;
    logic        r_ovalid;

    logic          w_start;
    logic [DW-1:0] w_num, w_den, w_quo;
    logic          w_busy;
    logic          r_dstart;
    logic [DW-1:0] r_dnum, r_dden;

    assign w_start = r_dstart;
    assign w_num   = r_dnum;
    assign w_den   = r_dden;

    msnp_div #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_busy), .o_quo(w_quo)
    );

    assign o_q_ready = (r_st == S_FETCH) && !r_ovalid;
    assign o_valid   = r_ovalid;
    assign o_res     = r_out;

    logic [7:0]  c;
    logic        dig;
    logic [15:0] w_acc10;
    logic [DW:0] w_dsum;
    logic [DW+3:0] w_t10;
    logic [15:0] w_nz;
    assign c       = r_cmd.ch;
    assign dig     = (c >= 8'h30) && (c <= 8'h39);
    assign w_acc10 = 16'(r_acc * 16'd10) + 16'(c - 8'h30);
    assign w_dsum  = {1'b0, r_pdur} + {1'b0, r_dinc};
    assign w_t10   = {w_quo, 3'b0} + {3'b0, w_quo, 1'b0};
    assign w_nz    = (r_acc == 16'd0) ? 16'd1 : r_acc;

    function automatic logic [3:0] key_of(input logic [7:0] k);
        case (k)
            8'h63: key_of = 4'd0;
            8'h64: key_of = 4'd2;
            8'h65: key_of = 4'd4;
            8'h66: key_of = 4'd5;
            8'h67: key_of = 4'd7;
            8'h61: key_of = 4'd9;
            8'h62: key_of = 4'd11;
            default: key_of = 4'd0;
        endcase
    endfunction

    // characters that idle parsing consumes without ending the sequence
    function automatic logic is_cmd(input logic [7:0] k);
        case (k)
            8'h3e, 8'h3c, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h61, 8'h62, 8'h72,
            8'h6c, 8'h6f, 8'h74, 8'h6d, 8'h21: is_cmd = 1'b1;
            default: is_cmd = 1'b0;
        endcase
    endfunction

    // saturating dot add
    logic [DW-1:0] w_dot;
    assign w_dot = w_dsum[DW] ? DurMax : w_dsum[DW-1:0];

    // closing character re-parsed in idle either ends the sequence or makes no word
    logic          w_end_next;
    logic [DW-1:0] w_gap;
    assign w_end_next = !is_cmd(c);
    assign w_gap      = r_stacc ? {1'b0, r_pdur[DW-1:1]} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_FETCH;
            r_ph <= PH_IDLE;
            r_dsel <= D_LEN;
            r_boct <= 8'd4;
            r_noct <= 8'd4;
            r_whole <= DW'(2000);
            r_ntype <= 16'd4;
            r_defdur <= DW'(500);
            r_stacc <= 1'b0;
            r_pnote <= '0;
            r_prest <= 1'b0;
            r_pdur <= '0;
            r_dinc <= '0;
            r_acc <= '0;
            r_ovalid <= 1'b0;
            r_dstart <= 1'b0;
            r_gap <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                S_FETCH: begin
                    if (i_q_valid && !r_ovalid) begin
                        r_cmd <= i_q_data;
                        r_st <= i_q_data.stop ? S_EMIT_END : S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_st <= S_FETCH;
                    case (r_ph)
                        PH_ARG_L, PH_ARG_O, PH_ARG_T: begin
                            if (dig) r_acc <= w_acc10;
                            else begin
                                r_acc <= '0;
                                r_ph <= PH_IDLE;
                                r_st <= S_EXEC;
                                if (r_ph == PH_ARG_O) begin
                                    r_boct <= r_acc[7:0];
                                    r_noct <= r_acc[7:0];
                                end else if (r_ph == PH_ARG_L) begin
                                    r_ntype <= w_nz;
                                    r_dnum <= r_whole;
                                    r_dden <= DW'(w_nz);
                                    r_dstart <= 1'b1;
                                    r_dsel <= D_LTYPE;
                                    r_st <= S_DIV_WAIT;
                                end else begin
                                    r_dnum <= DW'(24000);
                                    r_dden <= DW'(w_nz);
                                    r_dstart <= 1'b1;
                                    r_dsel <= D_TEMPO;
                                    r_st <= S_DIV_WAIT;
                                end
                            end
                        end
                        PH_MODE: begin
                            r_stacc <= (c != 8'h6c);
                            r_ph <= PH_IDLE;
                        end
                        PH_SHARP, PH_FLAT: begin
                            if (r_ph == PH_SHARP && (c == 8'h2b || c == 8'h23))
                                r_pnote <= r_pnote + 8'd1;
                            else if (c == 8'h2d) begin
                                r_pnote <= r_pnote - 8'd1;
                                r_ph <= PH_FLAT;
                            end else if (c > 8'h30 && c < 8'h39) begin
                                r_acc <= 16'(c - 8'h30);
                                r_ph <= PH_LEN;
                            end else if (c == 8'h2e) begin
                                r_pdur <= (({1'b0, r_pdur} + {2'b0, r_pdur[DW-1:1]})
                                           > {1'b0, DurMax}) ? DurMax
                                          : r_pdur + {1'b0, r_pdur[DW-1:1]};
                                r_dinc <= {1'b0, r_pdur[DW-1:1]} >> 1;
                                r_ph <= PH_DOTS;
                            end else begin
                                r_st <= S_EMIT_NOTE;
                            end
                        end
                        PH_LEN: begin
                            if (dig) r_acc <= w_acc10;
                            else begin
                                r_dnum <= r_whole;
                                r_dden <= DW'(w_nz);
                                r_dstart <= 1'b1;
                                r_dsel <= D_LEN;
                                r_st <= S_DIV_WAIT;
                            end
                        end
                        PH_DOTS: begin
                            if (c == 8'h2e) begin
                                r_pdur <= w_dot;
                                r_dinc <= r_dinc >> 1;
                            end else begin
                                r_st <= S_EMIT_NOTE;
                            end
                        end
                        PH_IDLE: begin
                            case (c)
                                8'h3e: r_noct <= r_noct + 8'd1;
                                8'h3c: r_noct <= r_noct - 8'd1;
                                8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h61, 8'h62,
                                8'h72: begin
                                    r_pnote <= 8'(key_of(c)) + 8'(r_noct * 8'd12);
                                    r_prest <= (c == 8'h72);
                                    r_pdur <= r_defdur;
                                    r_dinc <= '0;
                                    r_ph <= PH_SHARP;
                                end
                                8'h6c: begin r_acc <= '0; r_ph <= PH_ARG_L; end
                                8'h6f: begin r_acc <= '0; r_ph <= PH_ARG_O; end
                                8'h74: begin r_acc <= '0; r_ph <= PH_ARG_T; end
                                8'h6d: r_ph <= PH_MODE;
                                8'h21: begin
                                    r_boct <= 8'd4;
                                    r_noct <= 8'd4;
                                    r_whole <= DW'(2000);
                                    r_ntype <= 16'd4;
                                    r_defdur <= DW'(500);
                                    r_stacc <= 1'b0;
                                end
                                default: r_st <= S_EMIT_END;
                            endcase
                        end
                        default: begin
                            r_ph <= PH_IDLE;
                            r_st <= S_EXEC;
                        end
                    endcase
                end
                S_DIV_WAIT: begin
                    if (!r_dstart && !w_busy) begin
                        case (r_dsel)
                            D_LEN: begin
                                r_pdur <= w_quo;
                                if (c == 8'h2e) begin
                                    r_pdur <= (({1'b0, w_quo} + {2'b0, w_quo[DW-1:1]})
                                               > {1'b0, DurMax}) ? DurMax
                                              : w_quo + {1'b0, w_quo[DW-1:1]};
                                    r_dinc <= {1'b0, w_quo[DW-1:1]} >> 1;
                                    r_ph <= PH_DOTS;
                                    r_st <= S_FETCH;
                                end else begin
                                    r_st <= S_EMIT_NOTE;
                                end
                            end
                            D_LTYPE, D_DEFDUR: begin
                                r_defdur <= w_quo;
                                r_st <= S_EXEC;
                            end
                            D_TEMPO: r_st <= S_T_MUL;
                            default: r_st <= S_EXEC;
                        endcase
                    end
                end
                S_T_MUL: begin
                    r_whole <= (w_t10 > {4'b0, DurMax}) ? DurMax : w_t10[DW-1:0];
                    r_dnum <= (w_t10 > {4'b0, DurMax}) ? DurMax : w_t10[DW-1:0];
                    r_dden <= DW'(r_ntype);
                    r_dstart <= 1'b1;
                    r_dsel <= D_DEFDUR;
                    r_st <= S_DIV_WAIT;
                end
                S_EMIT_NOTE: begin
                    if (!r_ovalid || i_ready) begin
                        r_gap <= w_gap;
                        r_out.kind <= KIND_NOTE;
                        r_out.note <= r_prest ? REST_NOTE : r_pnote;
                        r_out.dur <= 16'(r_stacc ? (r_pdur - {1'b0, r_pdur[DW-1:1]})
                                                 : r_pdur);
                        if (r_stacc ? (r_pdur - {1'b0, r_pdur[DW-1:1]}) > DW'(16'hffff)
                                    : r_pdur > DW'(16'hffff))
                            r_out.dur <= 16'hffff;
                        r_out.last <= (w_gap == '0) && !w_end_next;
                        r_ovalid <= 1'b1;
                        r_noct <= r_boct;
                        r_pnote <= '0;
                        r_prest <= 1'b0;
                        r_pdur <= '0;
                        r_dinc <= '0;
                        r_acc <= '0;
                        r_ph <= PH_IDLE;
                        r_st <= S_EMIT_GAP;
                    end
                end
                S_EMIT_GAP: begin
                    if (r_gap == '0) r_st <= S_EXEC;
                    else if (!r_ovalid || i_ready) begin
                        r_out.kind <= KIND_GAP;
                        r_out.note <= REST_NOTE;
                        r_out.dur <= (r_gap > DW'(16'hffff)) ? 16'hffff : 16'(r_gap);
                        r_out.last <= !w_end_next;
                        r_ovalid <= 1'b1;
                        r_st <= S_EXEC;
                    end
                end
                S_EMIT_END: begin
                    if (!r_ovalid || i_ready) begin
                        r_out.kind <= KIND_END;
                        r_out.note <= REST_NOTE;
                        r_out.dur <= '0;
                        r_out.last <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_noct <= r_boct;
                        r_pnote <= '0;
                        r_prest <= 1'b0;
                        r_pdur <= '0;
                        r_dinc <= '0;
                        r_acc <= '0;
                        r_ph <= PH_IDLE;
                        r_st <= S_FETCH;
                    end
                end
                S_OUT: r_st <= S_FETCH;
                default: r_st <= S_FETCH;
            endcase
        end
    end

    `MSNP_ASSERT_IMP(a_fetch_no_out, i_clk, i_rst_n, o_q_ready, !r_ovalid,
        "fetch while result pending")
    `MSNP_ASSERT_NXT(a_end_last, i_clk, i_rst_n,
        (r_st == S_EMIT_END) && (!r_ovalid || i_ready), o_res.last,
        "end result lacks last")
    `MSNP_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_st == S_FETCH, !w_busy,
        "divider busy while fetching")
endmodule
